@@ rtl/weekly_schedule_timed_relays_assert.svh @@
// Assertion macros for the RTL of the weekly schedule relay block.
`ifndef WEEKLY_SCHEDULE_TIMED_RELAYS_ASSERT_SVH
`define WEEKLY_SCHEDULE_TIMED_RELAYS_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, checked on every rising edge outside reset.
`define WSTR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define WSTR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define WSTR_ASSERT_IMP(label, ante, cons)
`define WSTR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/wstr_pkg.sv @@
// Types, constants and helpers of the weekly schedule relay block.
package wstr_pkg;

	localparam int SCHEDULE_SLOTS_DEF = 4;
	localparam int RELAY_COUNT_DEF    = 3;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 37;
	localparam int ACTIVE_W   = 3;
	localparam int RELAY_W    = 2;
	localparam int DUR_W      = 16;
	localparam int KEY_W      = 20;
	localparam int MASK_W     = 3;

	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLUG   = 3'd1;
	localparam int REG_SLOT_BASE = 2;

	localparam logic MODE_TICK   = 1'b0;
	localparam logic MODE_MANUAL = 1'b1;

	localparam logic [RELAY_W-1:0] PLUG_RELAY   = 2'd3;
	localparam logic [2:0]         WEEKDAY_LAST = 3'd6;

	typedef logic [KEY_W-1:0] key_t;

	typedef struct packed {
		logic [DUR_W-1:0]   dur;
		logic [RELAY_W-1:0] relay;
		logic [5:0]         minute;
		logic [4:0]         hour;
		logic [6:0]         wmask;
		logic               en;
	} sched_slot_t;

	typedef struct packed {
		logic         mode;
		logic         time_valid;
		logic [3:0]   month;
		logic [4:0]   day_of_month;
		logic [2:0]   weekday;
		logic [4:0]   hour;
		logic [5:0]   minute;
		logic [1:0]   manual_relay;
		logic         manual_on;
	} item_t;

	typedef struct packed {
		logic [MASK_W-1:0] relay_levels;
		logic [MASK_W-1:0] started_mask;
		logic [MASK_W-1:0] expired_mask;
	} result_t;

	// Calendar minute key: month, day, hour, minute packed side by side.
	function automatic key_t make_key(input item_t it);
		return {it.month, it.day_of_month, it.hour, it.minute};
	endfunction

endpackage

@@ rtl/wstr_item_if.sv @@
// Valid/ready channel that carries input beats (ticks and manual commands).
interface wstr_item_if;
	import wstr_pkg::*;

	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/wstr_result_if.sv @@
// Valid/ready channel that carries result beats.
interface wstr_result_if;
	import wstr_pkg::*;

	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/weekly_schedule_timed_relays.sv @@
// Top level of the weekly schedule relay block: channels, input and result registers.
//
// Usage:
//   items   : input beats, each a one-second tick with wall-clock time (mode 0)
//             or a manual relay on/off command (mode 1).
//   results : one result beat per input beat, in order: relay levels after the
//             beat, relays started by a schedule, relays switched off by timer.
//   write_en / reg_index / write_data : configuration writes, taken on any edge
//             with write_en high; write only while no beat is in flight.
// A beat accepted into the input register shows on results once the
//   single-pass update loads the result register.
// Throughput: one beat per cycle while results.ready is high; the tick (timer
//   countdown, slot comparators, in-order fire resolution) is one combinational pass.
// Reset: arst_n low clears all relays, timers, fire history and configuration
//   registers; results.valid drops and both pipeline registers empty.
// Stall: while results.ready is low the result register holds; the input
//   register still takes one more beat, then items.ready drops until the
//   result is taken.
module weekly_schedule_timed_relays #(
	parameter int SCHEDULE_SLOTS = wstr_pkg::SCHEDULE_SLOTS_DEF,
	parameter int RELAY_COUNT    = wstr_pkg::RELAY_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	wstr_item_if.sink                       items,
	wstr_result_if.source                   results,
	input  logic                            write_en,
	input  logic [wstr_pkg::CFG_IDX_W-1:0]  reg_index,
	input  logic [wstr_pkg::CFG_DATA_W-1:0] write_data
);
	import wstr_pkg::*;
	`include "weekly_schedule_timed_relays_assert.svh"

	logic                active;
	logic [ACTIVE_W-1:0] active_cnt;
	logic                plug_en;
	sched_slot_t         slots [SCHEDULE_SLOTS];

	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t result_q;
	result_t core_result;
	logic    advance;
	logic    run;

	// configuration registers
	wstr_cfg_regs #(
		.SCHEDULE_SLOTS (SCHEDULE_SLOTS)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.write_en   (write_en),
		.reg_index  (reg_index),
		.write_data (write_data),
		.active     (active_cnt),
		.plug_en    (plug_en),
		.slots      (slots)
	);

	// result register is free, or its beat leaves this cycle
	assign advance = !out_valid_q || results.ready;
	// process the held beat when it can move into the result register
	assign run     = valid_s1 && advance;
	assign active  = valid_s1 || out_valid_q;

	assign items.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			item_s1 <= items.data;
		end
	end

	// state update and result computation
	wstr_relay_core #(
		.SCHEDULE_SLOTS (SCHEDULE_SLOTS),
		.RELAY_COUNT    (RELAY_COUNT)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.run     (run),
		.item    (item_s1),
		.active  (active_cnt),
		.plug_en (plug_en),
		.slots   (slots),
		.result  (core_result)
	);

	// result register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (run) begin
			result_q <= core_result;
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = result_q;

	// a relay started by a schedule is on after the beat
	`WSTR_ASSERT_IMP(a_started_on, results.valid,
		(results.data.started_mask & ~results.data.relay_levels) == '0)
	// a relay that expired and was not restarted is off after the beat
	`WSTR_ASSERT_IMP(a_expired_off, results.valid,
		(results.data.expired_mask & ~results.data.started_mask
			& results.data.relay_levels) == '0)
	// a processed beat always lands in the result register
	`WSTR_ASSERT_NEXT(a_run_lands, run, out_valid_q)
	// nothing in flight means both registers are empty
	`WSTR_ASSERT_IMP(a_idle_empty, !active, !results.valid && items.ready)
endmodule

@@ rtl/wstr_cfg_regs.sv @@
// Configuration register file: active slot count, plug enable, schedule slots.
module wstr_cfg_regs #(
	parameter int SCHEDULE_SLOTS = wstr_pkg::SCHEDULE_SLOTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               write_en,
	input  logic [wstr_pkg::CFG_IDX_W-1:0]     reg_index,
	input  logic [wstr_pkg::CFG_DATA_W-1:0]    write_data,
	output logic [wstr_pkg::ACTIVE_W-1:0]      active,
	output logic                               plug_en,
	output wstr_pkg::sched_slot_t              slots [SCHEDULE_SLOTS]
);
	import wstr_pkg::*;

	logic [ACTIVE_W-1:0] active_q;
	logic                plug_q;
	sched_slot_t         slot_q [SCHEDULE_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			plug_q   <= 1'b0;
			for (int i = 0; i < SCHEDULE_SLOTS; i++) begin
				slot_q[i] <= '0;
			end
		end else if (write_en) begin
			if (reg_index == REG_ACTIVE) begin
				active_q <= write_data[ACTIVE_W-1:0];
			end
			if (reg_index == REG_PLUG) begin
				plug_q <= write_data[0];
			end
			for (int i = 0; i < SCHEDULE_SLOTS; i++) begin
				if (reg_index == CFG_IDX_W'(REG_SLOT_BASE + i)) begin
					slot_q[i] <= sched_slot_t'(write_data);
				end
			end
		end
	end

	assign active  = active_q;
	assign plug_en = plug_q;
	assign slots   = slot_q;
endmodule

@@ rtl/wstr_sched_match.sv @@
// Per-slot schedule comparators: which slots want to fire on this tick.
module wstr_sched_match #(
	parameter int SCHEDULE_SLOTS = wstr_pkg::SCHEDULE_SLOTS_DEF,
	parameter int RELAY_COUNT    = wstr_pkg::RELAY_COUNT_DEF
) (
	input  wstr_pkg::item_t                item,
	input  logic [wstr_pkg::ACTIVE_W-1:0]  active,
	input  logic                           plug_en,
	input  wstr_pkg::sched_slot_t          slots [SCHEDULE_SLOTS],
	input  wstr_pkg::key_t                 last_fire [SCHEDULE_SLOTS],
	output logic [SCHEDULE_SLOTS-1:0]      hit
);
	import wstr_pkg::*;

	key_t key;
	logic clock_ok;

	assign key      = make_key(item);
	assign clock_ok = item.time_valid && (item.weekday <= WEEKDAY_LAST);

	always_comb begin
		for (int i = 0; i < SCHEDULE_SLOTS; i++) begin
			hit[i] = clock_ok
				&& (active > ACTIVE_W'(i))
				&& slots[i].en
				&& ({1'b0, slots[i].wmask} >> item.weekday) != 8'd0
				&& (({1'b0, slots[i].wmask} >> item.weekday) & 8'd1) != 8'd0
				&& (slots[i].hour == item.hour)
				&& (slots[i].minute == item.minute)
				&& (last_fire[i] != key)
				&& (slots[i].relay != '0)
				&& ({1'b0, slots[i].relay} <= 3'(RELAY_COUNT))
				&& !(slots[i].relay == PLUG_RELAY && !plug_en);
		end
	end
endmodule

@@ rtl/wstr_relay_core.sv @@
// Relay state, run timers and per-slot fire history; one item per cycle while run is high.
module wstr_relay_core #(
	parameter int SCHEDULE_SLOTS = wstr_pkg::SCHEDULE_SLOTS_DEF,
	parameter int RELAY_COUNT    = wstr_pkg::RELAY_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           run,
	input  wstr_pkg::item_t                item,
	input  logic [wstr_pkg::ACTIVE_W-1:0]  active,
	input  logic                           plug_en,
	input  wstr_pkg::sched_slot_t          slots [SCHEDULE_SLOTS],
	output wstr_pkg::result_t              result
);
	import wstr_pkg::*;

	logic [DUR_W-1:0]        secs_q  [RELAY_COUNT];
	logic [RELAY_COUNT-1:0]  armed_q;
	logic [RELAY_COUNT-1:0]  level_q;
	key_t                    last_q  [SCHEDULE_SLOTS];

	logic [DUR_W-1:0]        secs_n  [RELAY_COUNT];
	logic [RELAY_COUNT-1:0]  armed_n;
	logic [RELAY_COUNT-1:0]  level_n;
	key_t                    last_n  [SCHEDULE_SLOTS];
	logic [RELAY_COUNT-1:0]  started;
	logic [RELAY_COUNT-1:0]  expired;
	logic [SCHEDULE_SLOTS-1:0] hit;
	key_t                    key;

	wstr_sched_match #(
		.SCHEDULE_SLOTS (SCHEDULE_SLOTS),
		.RELAY_COUNT    (RELAY_COUNT)
	) u_match (
		.item      (item),
		.active    (active),
		.plug_en   (plug_en),
		.slots     (slots),
		.last_fire (last_q),
		.hit       (hit)
	);

	assign key = make_key(item);

	always_comb begin
		secs_n  = secs_q;
		armed_n = armed_q;
		level_n = level_q;
		last_n  = last_q;
		started = '0;
		expired = '0;
		if (item.mode == MODE_MANUAL) begin
			for (int r = 0; r < RELAY_COUNT; r++) begin
				if (item.manual_relay == RELAY_W'(r + 1)) begin
					level_n[r] = item.manual_on;
				end
			end
		end else begin
			// count down armed timers first
			for (int r = 0; r < RELAY_COUNT; r++) begin
				if (armed_q[r]) begin
					if (secs_q[r] <= DUR_W'(1)) begin
						secs_n[r]  = '0;
						armed_n[r] = 1'b0;
						level_n[r] = 1'b0;
						expired[r] = 1'b1;
					end else begin
						secs_n[r] = secs_q[r] - DUR_W'(1);
					end
				end
			end
			// slots in order; an earlier slot that arms a relay blocks later ones
			for (int i = 0; i < SCHEDULE_SLOTS; i++) begin
				for (int r = 0; r < RELAY_COUNT; r++) begin
					if (hit[i] && slots[i].relay == RELAY_W'(r + 1) && !armed_n[r]) begin
						last_n[i]  = key;
						secs_n[r]  = slots[i].dur;
						armed_n[r] = (slots[i].dur != '0);
						level_n[r] = 1'b1;
						started[r] = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= '0;
			level_q <= '0;
			for (int r = 0; r < RELAY_COUNT; r++) begin
				secs_q[r] <= '0;
			end
			for (int i = 0; i < SCHEDULE_SLOTS; i++) begin
				last_q[i] <= '0;
			end
		end else if (run) begin
			armed_q <= armed_n;
			level_q <= level_n;
			secs_q  <= secs_n;
			last_q  <= last_n;
		end
	end

	assign result.relay_levels = MASK_W'(level_n);
	assign result.started_mask = MASK_W'(started);
	assign result.expired_mask = MASK_W'(expired);
endmodule
